/* sv/ssb_pkg.sv */
`default_nettype none

package ssb_pkg;

    localparam int MAX_SPRITE_SIDE   = 64;
    localparam int MAX_SCREEN_WIDTH  = 1024;
    localparam int MAX_SCREEN_HEIGHT = 1024;

    localparam int TEXEL_DEPTH = MAX_SPRITE_SIDE * MAX_SPRITE_SIDE;
    localparam int TEX_AW      = $clog2(TEXEL_DEPTH);
    localparam int DEP_AW      = $clog2(MAX_SCREEN_WIDTH);
    localparam int SIDE_W      = $clog2(MAX_SPRITE_SIDE + 1);
    localparam int SW_W        = $clog2(MAX_SCREEN_WIDTH + 1);
    localparam int SH_W        = $clog2(MAX_SCREEN_HEIGHT + 1);

    localparam int SCR_CFG_W = 11;
    localparam int SPR_CFG_W = 7;
    localparam int CFG_IDX_W = 2;

    localparam int FUNC_W    = 2;
    localparam int LADDR_W   = 12;
    localparam int TEXEL_W   = 32;
    localparam int POS_W     = 12;
    localparam int INV_W     = 24;
    localparam int DEPTH_W   = 24;
    localparam int PA_W      = 20;
    localparam int STATUS_W  = 3;

    localparam int COORD_W   = POS_W + 2;
    localparam int MULA_W    = POS_W + 1;
    localparam int PROD_W    = MULA_W + INV_W;
    localparam int SRC_SHIFT = 17;
    localparam int SRC_W     = PROD_W - SRC_SHIFT;
    localparam int SXM_W     = SRC_W + 2;
    localparam int ROW_W     = COORD_W - 1 + SW_W;
    localparam int IDX_W     = 2 * SIDE_W + 1;

    localparam int IN_TDATA_W  = 144;
    localparam int OUT_TDATA_W = 56;

    localparam logic [SCR_CFG_W-1:0] RST_SCREEN_W = 11'd320;
    localparam logic [SCR_CFG_W-1:0] RST_SCREEN_H = 11'd200;
    localparam logic [SPR_CFG_W-1:0] RST_SPRITE_W = 7'd64;
    localparam logic [SPR_CFG_W-1:0] RST_SPRITE_H = 7'd64;

    localparam logic [7:0] ALPHA_MIN = 8'd128;

    typedef enum logic [FUNC_W-1:0] {
        FN_TEXEL = 2'd0,
        FN_DEPTH = 2'd1,
        FN_DRAW  = 2'd2
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCREEN_W = 2'd0,
        CFG_SCREEN_H = 2'd1,
        CFG_SPRITE_W = 2'd2,
        CFG_SPRITE_H = 2'd3
    } t_cfg_reg;

    typedef enum logic [STATUS_W-1:0] {
        ST_WRITTEN = 3'd0,
        ST_NEG     = 3'd1,
        ST_TRANSP  = 3'd2,
        ST_OFFSCR  = 3'd3,
        ST_BEHIND  = 3'd4,
        ST_LOAD    = 3'd5
    } t_status;

    typedef struct packed {
        logic [SW_W-1:0]   sw;
        logic [SH_W-1:0]   sh;
        logic [SIDE_W-1:0] spw;
        logic [SIDE_W-1:0] sph;
    } t_cfg;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [LADDR_W-1:0] laddr;
        logic [TEXEL_W-1:0] lval;
        logic [POS_W-1:0]   ox;
        logic [POS_W-1:0]   oy;
        logic [POS_W-1:0]   offx;
        logic [POS_W-1:0]   offy;
        logic [INV_W-1:0]   inv;
        logic               mir;
        logic [DEPTH_W-1:0] sdepth;
        logic               dtest;
    } t_item;

    typedef struct packed {
        logic [FUNC_W-1:0]         func;
        logic [LADDR_W-1:0]        laddr;
        logic [TEXEL_W-1:0]        lval;
        logic [PROD_W-1:0]         prod_x;
        logic [PROD_W-1:0]         prod_y;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic                      mir;
        logic [DEPTH_W-1:0]        sdepth;
        logic                      dtest;
    } t_s1;

    typedef struct packed {
        logic [FUNC_W-1:0]         func;
        logic [LADDR_W-1:0]        laddr;
        logic [TEXEL_W-1:0]        lval;
        logic [SIDE_W-1:0]         sx;
        logic [SIDE_W-1:0]         sy;
        logic                      neg;
        logic                      offscr;
        logic [PA_W-1:0]           row;
        logic signed [COORD_W-1:0] px;
        logic [DEPTH_W-1:0]        sdepth;
        logic                      dtest;
    } t_s2;

    typedef struct packed {
        logic               is_load;
        logic               neg;
        logic               offscr;
        logic [PA_W-1:0]    addr;
        logic [DEPTH_W-1:0] sdepth;
        logic               dtest;
    } t_s3;

    typedef struct packed {
        logic               we;
        logic [PA_W-1:0]    addr;
        logic [TEXEL_W-1:0] value;
        t_status            status;
    } t_res;

    function automatic logic [SW_W-1:0] sat_scr_w(input logic [SCR_CFG_W-1:0] v);
        if (v == '0) begin
            return SW_W'(1);
        end else if (32'(v) > MAX_SCREEN_WIDTH) begin
            return SW_W'(MAX_SCREEN_WIDTH);
        end else begin
            return SW_W'(v);
        end
    endfunction

    function automatic logic [SH_W-1:0] sat_scr_h(input logic [SCR_CFG_W-1:0] v);
        if (v == '0) begin
            return SH_W'(1);
        end else if (32'(v) > MAX_SCREEN_HEIGHT) begin
            return SH_W'(MAX_SCREEN_HEIGHT);
        end else begin
            return SH_W'(v);
        end
    endfunction

    function automatic logic [SIDE_W-1:0] sat_side(input logic [SPR_CFG_W-1:0] v);
        if (v == '0) begin
            return SIDE_W'(1);
        end else if (32'(v) > MAX_SPRITE_SIDE) begin
            return SIDE_W'(MAX_SPRITE_SIDE);
        end else begin
            return SIDE_W'(v);
        end
    endfunction

endpackage

`default_nettype wire

/* sv/ssb_coord.sv */
`default_nettype none

module ssb_coord
    import ssb_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_adv,
    input  wire logic  i_valid,
    input  wire t_item i_item,
    input  wire t_cfg  i_cfg,
    output logic       o_valid,
    output t_s2        o_s2
);

    logic                      r1_valid;
    t_s1                       r1;
    t_s1                       n1;
    logic                      r2_valid;
    t_s2                       r2;
    t_s2                       n2;

    logic [MULA_W-1:0]         mul_x;
    logic [MULA_W-1:0]         mul_y;
    logic [SRC_W-1:0]          sx_raw;
    logic [SRC_W-1:0]          sy_raw;
    logic signed [SXM_W-1:0]   spw_s;
    logic signed [SXM_W-1:0]   sxm;
    logic signed [SXM_W-1:0]   sxc;
    logic [COORD_W-2:0]        py_u;
    logic [ROW_W-1:0]          row_full;

    // stage 1: source multiplies and screen position
    always_comb begin
        mul_x     = {i_item.offx, 1'b1};
        mul_y     = {i_item.offy, 1'b1};
        n1.func   = i_item.func;
        n1.laddr  = i_item.laddr;
        n1.lval   = i_item.lval;
        n1.prod_x = mul_x * i_item.inv;
        n1.prod_y = mul_y * i_item.inv;
        n1.px     = $signed({{2{i_item.ox[POS_W-1]}}, i_item.ox})
                  + $signed({2'b00, i_item.offx});
        n1.py     = $signed({{2{i_item.oy[POS_W-1]}}, i_item.oy})
                  + $signed({2'b00, i_item.offy});
        n1.mir    = i_item.mir;
        n1.sdepth = i_item.sdepth;
        n1.dtest  = i_item.dtest;
    end

    // stage 2: mirror, clamp, clip and row base
    always_comb begin
        sx_raw   = r1.prod_x[PROD_W-1:SRC_SHIFT];
        sy_raw   = r1.prod_y[PROD_W-1:SRC_SHIFT];
        spw_s    = $signed(SXM_W'(i_cfg.spw));
        sxm      = r1.mir ? (spw_s - $signed(SXM_W'(sx_raw)) - SXM_W'(1))
                          : $signed(SXM_W'(sx_raw));
        sxc      = (sxm >= spw_s) ? (spw_s - SXM_W'(1)) : sxm;
        py_u     = r1.py[COORD_W-2:0];
        row_full = py_u * i_cfg.sw;

        n2.func   = r1.func;
        n2.laddr  = r1.laddr;
        n2.lval   = r1.lval;
        n2.neg    = sxm[SXM_W-1];
        n2.sx     = sxc[SIDE_W-1:0];
        n2.sy     = (sy_raw >= SRC_W'(i_cfg.sph)) ? (i_cfg.sph - SIDE_W'(1))
                                                  : sy_raw[SIDE_W-1:0];
        n2.offscr = (r1.px < 0) || (r1.px >= $signed(COORD_W'(i_cfg.sw)))
                 || (r1.py < 0) || (r1.py >= $signed(COORD_W'(i_cfg.sh)));
        n2.row    = row_full[PA_W-1:0];
        n2.px     = r1.px;
        n2.sdepth = r1.sdepth;
        n2.dtest  = r1.dtest;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else if (i_adv) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1 <= n1;
            r2 <= n2;
        end
    end

    assign o_valid = r2_valid;
    assign o_s2    = r2;

endmodule

`default_nettype wire

/* sv/ssb_store.sv */
`default_nettype none

module ssb_store
    import ssb_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_adv,
    input  wire logic                i_valid,
    input  wire t_s2                 i_s2,
    input  wire t_cfg                i_cfg,
    output logic                     o_valid,
    output t_s3                      o_s3,
    output logic [TEXEL_W-1:0]       o_texel,
    output logic [DEPTH_W-1:0]       o_depth
);

    logic [TEXEL_W-1:0] r_tex_mem [TEXEL_DEPTH];
    logic [DEPTH_W-1:0] r_dep_mem [MAX_SCREEN_WIDTH];

    logic               r3_valid;
    t_s3                r3;
    t_s3                n3;
    logic [TEXEL_W-1:0] r_texel;
    logic [DEPTH_W-1:0] r_depth;

    logic [IDX_W-1:0]   idx_full;
    logic [TEX_AW-1:0]  tex_raddr;
    logic [DEP_AW-1:0]  dep_raddr;
    logic               tex_we;
    logic               dep_we;

    always_comb begin
        idx_full  = i_s2.sy * i_cfg.spw + i_s2.sx;
        tex_raddr = idx_full[TEX_AW-1:0];
        dep_raddr = DEP_AW'(i_s2.px);
        tex_we    = i_adv && i_valid && (i_s2.func == FN_TEXEL)
                 && (32'(i_s2.laddr) < 32'(TEXEL_DEPTH));
        dep_we    = i_adv && i_valid && (i_s2.func == FN_DEPTH)
                 && (32'(i_s2.laddr) < 32'(MAX_SCREEN_WIDTH));

        n3.is_load = (i_s2.func != FN_DRAW);
        n3.neg     = i_s2.neg;
        n3.offscr  = i_s2.offscr;
        n3.addr    = i_s2.row + PA_W'(i_s2.px);
        n3.sdepth  = i_s2.sdepth;
        n3.dtest   = i_s2.dtest;
    end

    always_ff @(posedge i_clk) begin
        if (tex_we) begin
            r_tex_mem[TEX_AW'(i_s2.laddr)] <= i_s2.lval;
        end
        if (dep_we) begin
            r_dep_mem[DEP_AW'(i_s2.laddr)] <= i_s2.lval[DEPTH_W-1:0];
        end
        if (i_adv) begin
            r_texel <= r_tex_mem[tex_raddr];
            r_depth <= r_dep_mem[dep_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (i_adv) begin
            r3_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r3 <= n3;
        end
    end

    assign o_valid = r3_valid;
    assign o_s3    = r3;
    assign o_texel = r_texel;
    assign o_depth = r_depth;

endmodule

`default_nettype wire

/* sv/ssb_skid.sv */
`default_nettype none

module ssb_skid
    import ssb_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire t_res i_res,
    output logic      o_ready,
    output logic      o_valid,
    output t_res      o_res,
    input  wire logic i_m_ready
);

    logic r_out_valid;
    logic n_out_valid;
    logic r_skid_valid;
    logic n_skid_valid;
    t_res r_out;
    t_res n_out;
    t_res r_skid;
    t_res n_skid;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (i_valid && !r_skid_valid) begin
            if (!r_out_valid || i_m_ready) begin
                n_out_valid = 1'b1;
                n_out       = i_res;
            end else begin
                n_skid_valid = 1'b1;
                n_skid       = i_res;
            end
        end else if (i_m_ready && r_out_valid) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

endmodule

`default_nettype wire

/* sv/scaled_sprite_blit_depth_test.sv */
`default_nettype none

// Channel   Direction  Handshake               Payload
// s (item)  in         i_s_tvalid / o_s_tready  i_s_tdata, i_s_tuser = func
// m (item)  out        o_m_tvalid / i_m_tready  o_m_tdata, o_m_tuser = status
// cfg       in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One item per cycle while o_s_tready is high; a result is offered once its item has passed four
// registers (two coordinate stages, one texel/depth memory read, one output register).
// Memory writes for loads and memory reads for draws share one stage, so
// items see every earlier load. Reset clears the valid flags and configuration only; the
// stores hold nothing valid until loaded. o_s_tready drops only while the
// skid register holds an item, and then every stage holds.

module scaled_sprite_blit_depth_test
    import ssb_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,

    input  wire logic                   i_s_tvalid,
    output logic                        o_s_tready,
    // load_address, load_value, origin_x, origin_y, offset_x, offset_y,
    // inv_scale, mirror, sprite_depth, depth_test, zero fill
    input  wire logic [IN_TDATA_W-1:0]  i_s_tdata,
    // func
    input  wire logic [FUNC_W-1:0]      i_s_tuser,

    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    // write_enable, pixel_address, pixel_value, zero fill
    output logic [OUT_TDATA_W-1:0]      o_m_tdata,
    // status
    output logic [STATUS_W-1:0]         o_m_tuser,

    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [SCR_CFG_W-1:0]   i_cfg_data
);

    t_cfg               r_cfg;
    t_item              item;
    logic               adv;
    logic               in_valid;
    logic               s2_valid;
    t_s2                s2;
    logic               s3_valid;
    t_s3                s3;
    logic [TEXEL_W-1:0] texel;
    logic [DEPTH_W-1:0] col_depth;
    t_res               res;
    t_res               m_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sw  <= sat_scr_w(RST_SCREEN_W);
            r_cfg.sh  <= sat_scr_h(RST_SCREEN_H);
            r_cfg.spw <= sat_side(RST_SPRITE_W);
            r_cfg.sph <= sat_side(RST_SPRITE_H);
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_SCREEN_W: r_cfg.sw  <= sat_scr_w(i_cfg_data);
                CFG_SCREEN_H: r_cfg.sh  <= sat_scr_h(i_cfg_data);
                CFG_SPRITE_W: r_cfg.spw <= sat_side(i_cfg_data[SPR_CFG_W-1:0]);
                CFG_SPRITE_H: r_cfg.sph <= sat_side(i_cfg_data[SPR_CFG_W-1:0]);
            endcase
        end
    end

    always_comb begin
        item.func   = i_s_tuser;
        item.laddr  = i_s_tdata[11:0];
        item.lval   = i_s_tdata[43:12];
        item.ox     = i_s_tdata[55:44];
        item.oy     = i_s_tdata[67:56];
        item.offx   = i_s_tdata[79:68];
        item.offy   = i_s_tdata[91:80];
        item.inv    = i_s_tdata[115:92];
        item.mir    = i_s_tdata[116];
        item.sdepth = i_s_tdata[140:117];
        item.dtest  = i_s_tdata[141];
    end

    // drop unused selector codes at the door
    assign in_valid = i_s_tvalid && adv
                   && ((i_s_tuser == FN_TEXEL) || (i_s_tuser == FN_DEPTH)
                    || (i_s_tuser == FN_DRAW));
    assign o_s_tready = adv;

    ssb_coord u_coord (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (in_valid),
        .i_item  (item),
        .i_cfg   (r_cfg),
        .o_valid (s2_valid),
        .o_s2    (s2)
    );

    ssb_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (s2_valid),
        .i_s2    (s2),
        .i_cfg   (r_cfg),
        .o_valid (s3_valid),
        .o_s3    (s3),
        .o_texel (texel),
        .o_depth (col_depth)
    );

    always_comb begin
        res.we     = 1'b0;
        res.addr   = '0;
        res.value  = '0;
        res.status = ST_WRITTEN;
        priority if (s3.is_load) begin
            res.status = ST_LOAD;
        end else if (s3.neg) begin
            res.status = ST_NEG;
        end else if (texel[31:24] < ALPHA_MIN) begin
            res.status = ST_TRANSP;
        end else if (s3.offscr) begin
            res.status = ST_OFFSCR;
        end else if (s3.dtest && !(s3.sdepth < col_depth)) begin
            res.status = ST_BEHIND;
        end else begin
            res.we    = 1'b1;
            res.addr  = s3.addr;
            res.value = texel;
        end
    end

    ssb_skid u_skid (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s3_valid),
        .i_res     (res),
        .o_ready   (adv),
        .o_valid   (o_m_tvalid),
        .o_res     (m_res),
        .i_m_ready (i_m_tready)
    );

    assign o_m_tdata = {3'b000, m_res.value, m_res.addr, m_res.we};
    assign o_m_tuser = m_res.status;

endmodule

`default_nettype wire
